// File: design/hole_fit_allocator_defines.svh
// Assertion macros shared by the hole fit allocator modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef HOLE_FIT_ALLOCATOR_DEFINES_SVH
`define HOLE_FIT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hole fit allocator: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hole fit allocator: next-cycle check failed");

`endif

// File: design/hfa_pkg.sv
// Package for the hole fit allocator: codes, field widths and the
// command/status structs between controller and datapath. No dependencies.
package hfa_pkg;

    localparam int DEF_MAX_HOLES = 32;
    localparam int DEF_SIZE_BITS = 16;

    localparam int ACTION_W = 2;
    localparam int SIZE_W   = 16;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 5;
    localparam int TOTAL_W  = 21;
    localparam int MODE_W   = 2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    typedef struct packed {
        logic accept;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_needed;
        logic scan_last;
    } t_sts;

endpackage

// File: design/hole_fit_allocator.sv
// Hole fit allocator: one item at a time. Clear, load and unused action codes,
// and a request against an empty table, go from acceptance to the commit state
// and then the result register; a request against a non-empty table first scans
// the hole size memory over its single read port one entry per cycle, while the
// pick is updated in the cycle after each read, then drains and commits. A
// result waits in the output register until taken, and the next item is
// accepted once the current one is committed. The size memory needs no
// clearing pass: only entries below the hole count are ever read.
// Depends on hfa_pkg, hfa_ctrl, hfa_datapath.
module hole_fit_allocator #(
    parameter int MAX_HOLES = hfa_pkg::DEF_MAX_HOLES,
    parameter int SIZE_BITS = hfa_pkg::DEF_SIZE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hfa_pkg::MODE_W-1:0]       i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [hfa_pkg::ACTION_W-1:0]     i_action,
    input  logic [hfa_pkg::SIZE_W-1:0]       i_size,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [hfa_pkg::STATUS_W-1:0]     o_status,
    output logic [hfa_pkg::INDEX_W-1:0]      o_hole_index,
    output logic [hfa_pkg::SIZE_W-1:0]       o_leftover,
    output logic [hfa_pkg::TOTAL_W-1:0]      o_internal_total,
    output logic [hfa_pkg::TOTAL_W-1:0]      o_external_total
);

    hfa_pkg::t_cmd cmd;
    hfa_pkg::t_sts sts;

    hfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    hfa_datapath #(
        .MAX_HOLES (MAX_HOLES),
        .SIZE_BITS (SIZE_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_action),
        .i_size           (i_size),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_status         (o_status),
        .o_hole_index     (o_hole_index),
        .o_leftover       (o_leftover),
        .o_internal_total (o_internal_total),
        .o_external_total (o_external_total)
    );

endmodule

// File: design/hfa_datapath.sv
// Datapath of the hole fit allocator: hole memory, used marks, scan and
// pick registers, totals and result registers. Depends on hfa_pkg.
`include "hole_fit_allocator_defines.svh"

module hfa_datapath #(
    parameter int MAX_HOLES = hfa_pkg::DEF_MAX_HOLES,
    parameter int SIZE_BITS = hfa_pkg::DEF_SIZE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hfa_pkg::MODE_W-1:0]       i_cfg_data,
    input  logic [hfa_pkg::ACTION_W-1:0]     i_action,
    input  logic [hfa_pkg::SIZE_W-1:0]       i_size,
    input  hfa_pkg::t_cmd                    i_cmd,
    output hfa_pkg::t_sts                    o_sts,
    output logic [hfa_pkg::STATUS_W-1:0]     o_status,
    output logic [hfa_pkg::INDEX_W-1:0]      o_hole_index,
    output logic [hfa_pkg::SIZE_W-1:0]       o_leftover,
    output logic [hfa_pkg::TOTAL_W-1:0]      o_internal_total,
    output logic [hfa_pkg::TOTAL_W-1:0]      o_external_total
);

    localparam int IW   = $clog2(MAX_HOLES);
    localparam int CW   = $clog2(MAX_HOLES + 1);
    localparam int TW   = hfa_pkg::TOTAL_W;
    localparam int SUMW = ((SIZE_BITS > TW) ? SIZE_BITS : TW) + 1;
    localparam logic [SUMW-1:0] SUM_MAX = SUMW'(hfa_pkg::TOTAL_MAX);

    logic [SIZE_BITS-1:0]          mem [MAX_HOLES];

    logic [hfa_pkg::MODE_W-1:0]    r_fit_mode;
    logic [hfa_pkg::ACTION_W-1:0]  r_action;
    logic [SIZE_BITS-1:0]          r_req;
    logic [CW-1:0]                 r_count,    n_count;
    logic [MAX_HOLES-1:0]          r_used,     n_used;
    logic [TW-1:0]                 r_int_sum,  n_int_sum;
    logic [TW-1:0]                 r_free_sum, n_free_sum;
    logic [IW-1:0]                 r_scan_idx;
    logic                          r_rd_vld;
    logic [SIZE_BITS-1:0]          r_rd_data;
    logic                          r_rd_used;
    logic [IW-1:0]                 r_rd_idx;
    logic                          r_pick_vld;
    logic [IW-1:0]                 r_pick_idx;
    logic [SIZE_BITS-1:0]          r_pick_size;
    logic [hfa_pkg::STATUS_W-1:0]  r_status,   n_status;
    logic [hfa_pkg::INDEX_W-1:0]   r_index,    n_index;
    logic [hfa_pkg::SIZE_W-1:0]    r_left,     n_left;

    logic                          full;
    logic                          load_wr;
    logic                          fits;
    logic                          take;
    logic [SIZE_BITS-1:0]          left;
    logic [SUMW-1:0]               free_add;
    logic [SUMW-1:0]               int_add;

    assign full    = (r_count >= CW'(MAX_HOLES));
    assign load_wr = i_cmd.commit && (r_action == hfa_pkg::ACT_LOAD) && !full;
    assign left    = r_pick_size - r_req;

    assign o_sts.scan_needed = (i_action == hfa_pkg::ACT_ALLOC) && (r_count != '0);
    assign o_sts.scan_last   = (CW'(r_scan_idx) == (r_count - CW'(1)));

    // Compare stage: one fetched entry per cycle against the current pick.
    always_comb begin
        fits = r_rd_vld && !r_rd_used && (r_rd_data >= r_req);
        take = 1'b0;
        if (fits) begin
            if (!r_pick_vld) begin
                take = 1'b1;
            end else if (r_fit_mode == hfa_pkg::MODE_BEST) begin
                take = (r_rd_data < r_pick_size);
            end else if (r_fit_mode == hfa_pkg::MODE_WORST) begin
                take = (r_rd_data >= r_pick_size);
            end
        end
    end

    always_comb begin
        free_add   = SUMW'(r_free_sum) + SUMW'(r_req);
        int_add    = SUMW'(r_int_sum) + SUMW'(left);
        n_count    = r_count;
        n_used     = r_used;
        n_int_sum  = r_int_sum;
        n_free_sum = r_free_sum;
        n_status   = hfa_pkg::ST_DONE;
        n_index    = '0;
        n_left     = '0;
        case (r_action)
            hfa_pkg::ACT_CLEAR: begin
                n_count    = '0;
                n_used     = '0;
                n_int_sum  = '0;
                n_free_sum = '0;
            end
            hfa_pkg::ACT_LOAD: begin
                if (full) begin
                    n_status = hfa_pkg::ST_FULL;
                end else begin
                    n_used[r_count[IW-1:0]] = 1'b0;
                    n_count    = r_count + CW'(1);
                    n_index    = hfa_pkg::INDEX_W'(r_count);
                    n_free_sum = (free_add > SUM_MAX) ? hfa_pkg::TOTAL_MAX : free_add[TW-1:0];
                end
            end
            hfa_pkg::ACT_ALLOC: begin
                if (!r_pick_vld) begin
                    n_status = hfa_pkg::ST_NOFIT;
                end else begin
                    n_used[r_pick_idx] = 1'b1;
                    n_index   = hfa_pkg::INDEX_W'(r_pick_idx);
                    n_left    = hfa_pkg::SIZE_W'(left);
                    n_int_sum = (int_add > SUM_MAX) ? hfa_pkg::TOTAL_MAX : int_add[TW-1:0];
                    if (SUMW'(r_free_sum) >= SUMW'(r_pick_size)) begin
                        n_free_sum = TW'(SUMW'(r_free_sum) - SUMW'(r_pick_size));
                    end else begin
                        n_free_sum = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Hole memory: one read port for the scan, one write port for loads.
    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            mem[r_count[IW-1:0]] <= r_req;
        end
        if (i_cmd.scan) begin
            r_rd_data <= mem[r_scan_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= hfa_pkg::MODE_FIRST;
            r_count    <= '0;
            r_used     <= '0;
            r_int_sum  <= '0;
            r_free_sum <= '0;
            r_rd_vld   <= 1'b0;
            r_pick_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fit_mode <= i_cfg_data;
            end
            r_rd_vld <= i_cmd.scan;
            if (i_cmd.accept) begin
                r_pick_vld <= 1'b0;
            end else if (take) begin
                r_pick_vld <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_count    <= n_count;
                r_used     <= n_used;
                r_int_sum  <= n_int_sum;
                r_free_sum <= n_free_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action   <= i_action;
            r_req      <= SIZE_BITS'(i_size);
            r_scan_idx <= '0;
        end else if (i_cmd.scan) begin
            r_scan_idx <= r_scan_idx + IW'(1);
        end
        if (i_cmd.scan) begin
            r_rd_used <= r_used[r_scan_idx];
            r_rd_idx  <= r_scan_idx;
        end
        if (take) begin
            r_pick_idx  <= r_rd_idx;
            r_pick_size <= r_rd_data;
        end
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_index  <= n_index;
            r_left   <= n_left;
        end
    end

    assign o_status         = r_status;
    assign o_hole_index     = r_index;
    assign o_leftover       = r_left;
    assign o_internal_total = r_int_sum;
    assign o_external_total = r_free_sum;

    `HFA_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_HOLES))
    `HFA_ASSERT_NXT(a_pick_fits, i_clk, i_rst_n, take, r_pick_size >= r_req)
    `HFA_ASSERT_NXT(a_scan_fetches, i_clk, i_rst_n, i_cmd.scan, r_rd_vld)

endmodule

// File: design/hfa_ctrl.sv
// Controller of the hole fit allocator: sequences accept, scan, drain and
// commit, and owns the result valid flag. Depends on hfa_pkg.
`include "hole_fit_allocator_defines.svh"

module hfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_stall,
    input  hfa_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output hfa_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.commit = (r_state == S_COMMIT) && (!r_out_valid || !i_out_stall);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.scan_needed ? S_SCAN : S_COMMIT;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (o_cmd.commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `HFA_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, o_cmd.accept, r_state != S_IDLE)
    `HFA_ASSERT_NXT(a_commit_gives_result, i_clk, i_rst_n, o_cmd.commit, r_out_valid)
    `HFA_ASSERT_NXT(a_scan_end_drains, i_clk, i_rst_n, o_cmd.scan && i_sts.scan_last, r_state == S_DRAIN)
    `HFA_ASSERT_IMP(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0({o_cmd.accept, o_cmd.scan, o_cmd.commit}))

endmodule
